FILE: rtl/e2r_pkg.sv
`default_nettype none
package e2r_pkg;

  localparam int unsigned AngleBitsDefault = 16;
  localparam int unsigned FracBitsDefault  = 14;
  localparam int unsigned FieldW = 16;
  localparam int unsigned NumCoef = 8;

  typedef struct packed {
    logic [FieldW-1:0] yaw_angle;
    logic [FieldW-1:0] pitch_angle;
    logic [FieldW-1:0] roll_angle;
  } req_t;

  typedef struct packed {
    logic signed [FieldW-1:0] r00;
    logic signed [FieldW-1:0] r01;
    logic signed [FieldW-1:0] r02;
    logic signed [FieldW-1:0] r10;
    logic signed [FieldW-1:0] r11;
    logic signed [FieldW-1:0] r12;
    logic signed [FieldW-1:0] r20;
    logic signed [FieldW-1:0] r21;
    logic signed [FieldW-1:0] r22;
  } rsp_t;

  // Odd Taylor coefficients of sin(pi/2*z), unsigned Q31.
  function automatic logic [31:0] sine_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0: c = 32'd3373259426;
      3'd1: c = 32'd1387197337;
      3'd2: c = 32'd171138612;
      3'd3: c = 32'd10053990;
      3'd4: c = 32'd344545;
      3'd5: c = 32'd7728;
      3'd6: c = 32'd122;
      default: c = 32'd1;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/e2r_sine.sv
`default_nettype none
// Pipelined sine in Q31: one Horner step per register stage.
// Every stage advances on en_i.
module e2r_sine
  import e2r_pkg::*;
#(
  parameter int unsigned AngleBits = AngleBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 en_i,
  input  wire logic [AngleBits-1:0] angle_i,
  output logic signed [32:0]        sine_o
);

  localparam int unsigned NStg = NumCoef;

  logic [31:0] z0_d;
  logic [31:0] z_q   [NStg+1];
  logic [31:0] w_q   [NStg+1];
  logic [31:0] acc_q [NStg+1];
  logic        neg_q [NStg+1];
  logic [63:0] sq;

  always_comb begin
    z0_d = {1'b0, angle_i[AngleBits-3:0], {(33-AngleBits){1'b0}}};
    if (angle_i[AngleBits-2]) begin
      z0_d = 32'h8000_0000 - z0_d;
    end
  end

  // Stage 0: z and w = z*z >> 31.
  assign sq = {32'd0, z0_d} * {32'd0, z0_d};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z_q[0]   <= z0_d;
      w_q[0]   <= sq[62:31];
      acc_q[0] <= sine_coef(3'd7);
      neg_q[0] <= angle_i[AngleBits-1];
    end
  end

  for (genvar s = 0; s < NStg; s++) begin : g_horner
    logic [63:0] p;
    assign p = {32'd0, acc_q[s]} * {32'd0, w_q[s]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[s+1]   <= z_q[s];
        w_q[s+1]   <= w_q[s];
        neg_q[s+1] <= neg_q[s];
        if (s == NStg-1) begin
          // Final step multiplies by z instead of w.
          acc_q[s+1] <= 32'({32'd0, acc_q[s]} * {32'd0, z_q[s]} >> 31);
        end else begin
          acc_q[s+1] <= sine_coef(3'(NStg-2-s)) - p[62:31];
        end
      end
    end
  end

  logic signed [32:0] sine_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sine_q <= neg_q[NStg] ? -$signed({1'b0, acc_q[NStg]})
                            : $signed({1'b0, acc_q[NStg]});
    end
  end
  assign sine_o = sine_q;

endmodule
`default_nettype wire

FILE: rtl/e2r_mul.sv
`default_nettype none
// Signed Q31 product with magnitude rounding half away from zero, registered.
module e2r_mul (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [32:0] a_i,
  input  wire logic signed [32:0] b_i,
  output logic signed [32:0]      p_o
);

  logic [32:0] ma, mb;
  logic [65:0] prod;
  logic [32:0] m;
  logic        neg;

  always_comb begin
    neg  = a_i[32] ^ b_i[32];
    ma   = a_i[32] ? 33'(-a_i) : 33'(a_i);
    mb   = b_i[32] ? 33'(-b_i) : 33'(b_i);
    prod = {33'd0, ma} * {33'd0, mb} + (66'd1 << 30);
    m    = prod[63:31];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg ? -$signed(m) : $signed(m);
    end
  end

endmodule
`default_nettype wire

FILE: rtl/euler_to_rotation_matrix.sv
`default_nettype none
// Yaw-pitch-roll rotation matrix from three binary angles.
//
// The input channel carries a request of three angles (req_valid_i,
// req_ready_o, req_i); the output channel carries the nine matrix entries
// in signed fixed point (rsp_valid_o, rsp_ready_i, rsp_o). Both channels
// complete a transfer when valid and ready are high at a rising edge.
//
// The block is a fully pipelined datapath: while the receiver does not stall,
// one request enters per cycle and one result leaves per cycle. The pipeline
// has 14 register stages: 10 for the Horner sine pipeline, 2 for the products
// (two-factor, then three-factor), 1 for the sums and 1 for rounding into the
// output register. Valid bits travel with the data.
//
// When the receiver stalls with a result waiting in the last stage, the
// whole pipeline freezes in place and req_ready_o drops; while the last
// stage is empty the pipeline keeps advancing as one. Nothing is lost or
// repeated. Reset clears every valid bit; data registers are not reset.
// No state is kept between requests.
module euler_to_rotation_matrix
  import e2r_pkg::*;
#(
  parameter int unsigned AngleBits = AngleBitsDefault,
  parameter int unsigned FracBits  = FracBitsDefault
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  output rsp_t      rsp_o
);

  localparam int unsigned SinLat = NumCoef + 2;
  localparam int unsigned Depth  = SinLat + 4;

  logic [Depth-1:0] vld_q;
  logic             en;

  // The pipeline advances unless a finished result waits at the output.
  assign en          = !vld_q[Depth-1] || rsp_ready_i;
  assign req_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], req_valid_i};
    end
  end

  // Sines and cosines; the cosine is the angle plus a quarter turn.
  logic [AngleBits-1:0] ang [3];
  logic signed [32:0]   sn  [3];
  logic signed [32:0]   cs  [3];
  localparam logic [AngleBits-1:0] Quarter = AngleBits'(1) << (AngleBits-2);

  assign ang[0] = AngleBits'(req_i.yaw_angle);
  assign ang[1] = AngleBits'(req_i.pitch_angle);
  assign ang[2] = AngleBits'(req_i.roll_angle);

  for (genvar i = 0; i < 3; i++) begin : g_trig
    e2r_sine #(.AngleBits(AngleBits)) u_sin (
      .clk_i, .en_i(en), .angle_i(ang[i]), .sine_o(sn[i]));
    e2r_sine #(.AngleBits(AngleBits)) u_cos (
      .clk_i, .en_i(en), .angle_i(ang[i] + Quarter), .sine_o(cs[i]));
  end

  logic signed [32:0] sy, cy, sp, cp, sr, cr;
  assign sy = sn[0]; assign cy = cs[0];
  assign sp = sn[1]; assign cp = cs[1];
  assign sr = sn[2]; assign cr = cs[2];

  // Product stage 1.
  logic signed [32:0] srsp, crsp, crcy, srcp, crsy, srcy, crcp, srsy, cpsy, cpcy;
  logic signed [32:0] sy1_q, cy1_q, sp1_q;
  e2r_mul u_m0 (.clk_i, .en_i(en), .a_i(sr), .b_i(sp), .p_o(srsp));
  e2r_mul u_m1 (.clk_i, .en_i(en), .a_i(cr), .b_i(sp), .p_o(crsp));
  e2r_mul u_m2 (.clk_i, .en_i(en), .a_i(cr), .b_i(cy), .p_o(crcy));
  e2r_mul u_m3 (.clk_i, .en_i(en), .a_i(sr), .b_i(cp), .p_o(srcp));
  e2r_mul u_m4 (.clk_i, .en_i(en), .a_i(cr), .b_i(sy), .p_o(crsy));
  e2r_mul u_m5 (.clk_i, .en_i(en), .a_i(sr), .b_i(cy), .p_o(srcy));
  e2r_mul u_m6 (.clk_i, .en_i(en), .a_i(cr), .b_i(cp), .p_o(crcp));
  e2r_mul u_m7 (.clk_i, .en_i(en), .a_i(sr), .b_i(sy), .p_o(srsy));
  e2r_mul u_m8 (.clk_i, .en_i(en), .a_i(cp), .b_i(sy), .p_o(cpsy));
  e2r_mul u_m9 (.clk_i, .en_i(en), .a_i(cp), .b_i(cy), .p_o(cpcy));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sy1_q <= sy;
      cy1_q <= cy;
      sp1_q <= sp;
    end
  end

  // Product stage 2: three-factor terms; two-factor terms are delayed.
  logic signed [32:0] t00, t02, t10, t12;
  logic signed [32:0] crcy_q, srcp_q, crsy_q, srcy_q, crcp_q, srsy_q;
  logic signed [32:0] cpsy_q, cpcy_q, sp2_q;
  e2r_mul u_t0 (.clk_i, .en_i(en), .a_i(srsp), .b_i(sy1_q), .p_o(t00));
  e2r_mul u_t1 (.clk_i, .en_i(en), .a_i(srsp), .b_i(cy1_q), .p_o(t02));
  e2r_mul u_t2 (.clk_i, .en_i(en), .a_i(crsp), .b_i(sy1_q), .p_o(t10));
  e2r_mul u_t3 (.clk_i, .en_i(en), .a_i(crsp), .b_i(cy1_q), .p_o(t12));

  always_ff @(posedge clk_i) begin
    if (en) begin
      crcy_q <= crcy; srcp_q <= srcp; crsy_q <= crsy; srcy_q <= srcy;
      crcp_q <= crcp; srsy_q <= srsy; cpsy_q <= cpsy; cpcy_q <= cpcy;
      sp2_q  <= sp1_q;
    end
  end

  // Sum stage.
  logic signed [34:0] s_q [9];
  always_ff @(posedge clk_i) begin
    if (en) begin
      s_q[0] <= 35'(crcy_q) + 35'(t00);
      s_q[1] <= 35'(srcp_q);
      s_q[2] <= 35'(t02) - 35'(crsy_q);
      s_q[3] <= 35'(t10) - 35'(srcy_q);
      s_q[4] <= 35'(crcp_q);
      s_q[5] <= 35'(srsy_q) + 35'(t12);
      s_q[6] <= 35'(cpsy_q);
      s_q[7] <= -35'(sp2_q);
      s_q[8] <= 35'(cpcy_q);
    end
  end

  // Rounding, saturation and the output register.
  localparam int unsigned Sh = 31 - FracBits;
  localparam logic [34:0] Lim = 35'd1 << FracBits;
  logic [FieldW-1:0] o_d [9];
  logic [FieldW-1:0] o_q [9];

  for (genvar j = 0; j < 9; j++) begin : g_out
    logic [34:0] mag, rnd;
    always_comb begin
      mag = s_q[j][34] ? 35'(-s_q[j]) : 35'(s_q[j]);
      rnd = (mag + (35'd1 << (Sh-1))) >> Sh;
      if (rnd > Lim) begin
        rnd = Lim;
      end
      o_d[j] = s_q[j][34] ? FieldW'(-rnd) : FieldW'(rnd);
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        o_q[j] <= o_d[j];
      end
    end
  end

  assign rsp_valid_o = vld_q[Depth-1];
  assign rsp_o = '{r00: o_q[0], r01: o_q[1], r02: o_q[2],
                   r10: o_q[3], r11: o_q[4], r12: o_q[5],
                   r20: o_q[6], r21: o_q[7], r22: o_q[8]};

endmodule
`default_nettype wire

FILE: rtl/e2r_checker.sv
`default_nettype none
module e2r_checker
  import e2r_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid_i,
  input wire logic req_ready_o,
  input wire logic rsp_valid_o,
  input wire logic rsp_ready_i,
  input wire rsp_t rsp_o
);

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result changed under stall");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_o |-> req_ready_o)
    else $error("not ready with empty output");

  a_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |-> !req_ready_o)
    else $error("request taken during stall");

  a_r11_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> rsp_o.r11 <= 16'sd16384 && rsp_o.r11 >= -16'sd16384)
    else $error("entry out of range");

endmodule

bind euler_to_rotation_matrix e2r_checker u_e2r_checker (
  .clk_i, .rst_ni, .req_valid_i, .req_ready_o, .rsp_valid_o, .rsp_ready_i, .rsp_o);
`default_nettype wire
